[src/htfl_pkg.sv]
// Shared types and constants for the handle table with free list and mark-sweep.
// Holds the function and status codes, the sequencer states and parameter defaults.
// No dependencies.
package htfl_pkg;

  localparam int unsigned NumHandlesDef    = 256;
  localparam int unsigned RefsPerHandleDef = 8;
  localparam int unsigned FieldW           = 16;
  localparam int unsigned RelCountW        = 8;

  typedef enum logic [2:0] {
    FN_ALLOC    = 3'd0,
    FN_RELEASE  = 3'd1,
    FN_PUSH     = 3'd2,
    FN_READ     = 3'd3,
    FN_RESET    = 3'd4,
    FN_GC_BEGIN = 3'd5,
    FN_GC_MARK  = 3'd6,
    FN_GC_END   = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HANDLE = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_LIST_FULL  = 3'd3,
    ST_BAD_INDEX  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_EXEC,
    SQ_SWEEP_RD,
    SQ_SWEEP_EX
  } seq_e;

endpackage

[src/handle_table_free_list_mark_sweep.sv]
// Handle table top level: slot, mark, free-stack and reference memories under one sequencer.
// Depends on htfl_pkg for codes, states and parameter defaults.
//
// Alloc, release, push, read and gc_mark first read the slot, free-stack and reference
// memories, then in the exec state update them and load the result word, which shows on the
// result ports with done_o high for one cycle; busy is low again in the cycle done_o is high,
// so a new word can start then. Reset and gc_begin walk every slot through the single write
// port of the slot or mark memory, one entry a cycle; the result word shows in the cycle after
// the last entry is written. gc_end reads and then updates each slot from handle 1 to below the
// high-water mark through the same ports, in a read state and then an update state per slot.
// After rst_ni rises busy stays high while the slot and mark memories are cleared.
// The receiver cannot stall: done_o is high for exactly one cycle, and the result word stays on
// the ports until the next one is loaded.
module handle_table_free_list_mark_sweep #(
  parameter int unsigned NumHandles    = htfl_pkg::NumHandlesDef,
  parameter int unsigned RefsPerHandle = htfl_pkg::RefsPerHandleDef,
  localparam int unsigned HandleW = $clog2(NumHandles),
  localparam int unsigned CntW    = $clog2(RefsPerHandle + 1),
  localparam int unsigned RidxW   = (RefsPerHandle > 1) ? $clog2(RefsPerHandle) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     func_i,
  input  logic [HandleW-1:0]             handle_i,
  input  logic [htfl_pkg::FieldW-1:0]    lines_ahead_i,
  input  logic [htfl_pkg::FieldW-1:0]    drawable_index_i,
  input  logic [RidxW-1:0]               ref_index_i,
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic [HandleW-1:0]             handle_out_o,
  output logic [CntW-1:0]                ref_count_o,
  output logic [htfl_pkg::FieldW-1:0]    lines_ahead_out_o,
  output logic [htfl_pkg::FieldW-1:0]    drawable_index_out_o,
  output logic [htfl_pkg::RelCountW-1:0] released_count_o
);

  localparam int unsigned AddrW = $clog2(NumHandles * RefsPerHandle);
  localparam int unsigned RefW  = 2 * htfl_pkg::FieldW;
  localparam int unsigned CtrW  = HandleW + 1;

  htfl_pkg::seq_e    state_q, state_d;
  logic [CtrW-1:0]   idx_q, idx_d;
  logic              clr_slot_q, clr_slot_d;
  logic              clr_mark_q, clr_mark_d;
  logic              clr_rep_q, clr_rep_d;
  logic [CtrW-1:0]   free_top_q, free_top_d;
  logic [CtrW-1:0]   high_water_q, high_water_d;
  logic [htfl_pkg::RelCountW-1:0] rel_q, rel_d;

  htfl_pkg::func_e   func_q;
  logic [HandleW-1:0] h_q;
  logic [htfl_pkg::FieldW-1:0] la_q, di_q;
  logic [RidxW-1:0]  ri_q;
  logic [AddrW-1:0]  base_q, ref_base;

  logic              done_q, done_d;
  htfl_pkg::status_e status_q, status_d;
  logic [HandleW-1:0] hout_q, hout_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [htfl_pkg::FieldW-1:0] lout_q, lout_d, dout_q, dout_d;
  logic [htfl_pkg::RelCountW-1:0] relout_q, relout_d;

  logic [CntW:0]     slot_mem [NumHandles];
  logic              mark_mem [NumHandles];
  logic [HandleW-1:0] free_mem [NumHandles];
  logic [RefW-1:0]   ref_mem  [NumHandles * RefsPerHandle];

  logic [CntW:0]     slot_rd_q;
  logic              mark_rd_q;
  logic [HandleW-1:0] free_rd_q;
  logic [RefW-1:0]   ref_rd_q;

  logic [HandleW-1:0] slot_raddr, free_raddr;
  logic [AddrW-1:0]  ref_raddr;
  logic              slot_we, mark_we, free_we, ref_we;
  logic [HandleW-1:0] slot_waddr, mark_waddr, free_waddr;
  logic [CntW:0]     slot_wdata;
  logic              mark_wdata;
  logic [HandleW-1:0] free_wdata;
  logic [AddrW-1:0]  ref_waddr;

  logic              accept;
  logic              h_in_range, slot_v;
  logic [CntW-1:0]   slot_len;
  logic [CtrW-1:0]   hw_one, free_top_m1;

  assign accept      = start && !busy;
  assign busy        = (state_q != htfl_pkg::SQ_IDLE);
  assign ref_base    = AddrW'(handle_i) * AddrW'(RefsPerHandle);
  assign free_top_m1 = free_top_q - CtrW'(1);
  assign slot_v      = slot_rd_q[CntW];
  assign slot_len    = slot_rd_q[CntW-1:0];
  assign h_in_range  = (h_q != '0) && (CtrW'(h_q) < high_water_q);
  assign hw_one      = (high_water_q == '0) ? CtrW'(1) : high_water_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    clr_slot_d   = clr_slot_q;
    clr_mark_d   = clr_mark_q;
    clr_rep_d    = clr_rep_q;
    free_top_d   = free_top_q;
    high_water_d = high_water_q;
    rel_d        = rel_q;
    done_d       = 1'b0;
    status_d     = status_q;
    hout_d       = hout_q;
    cnt_d        = cnt_q;
    lout_d       = lout_q;
    dout_d       = dout_q;
    relout_d     = relout_q;

    slot_raddr = (state_q == htfl_pkg::SQ_IDLE) ? handle_i : idx_q[HandleW-1:0];
    free_raddr = free_top_m1[HandleW-1:0];
    ref_raddr  = ref_base + AddrW'(ref_index_i);

    slot_we    = 1'b0;
    slot_waddr = h_q;
    slot_wdata = '0;
    mark_we    = 1'b0;
    mark_waddr = h_q;
    mark_wdata = 1'b0;
    free_we    = 1'b0;
    free_waddr = free_top_q[HandleW-1:0];
    free_wdata = h_q;
    ref_we     = 1'b0;
    ref_waddr  = base_q + AddrW'(slot_len);

    case (state_q)
      htfl_pkg::SQ_CLEAR: begin
        slot_we    = clr_slot_q;
        slot_waddr = idx_q[HandleW-1:0];
        mark_we    = clr_mark_q;
        mark_waddr = idx_q[HandleW-1:0];
        idx_d      = idx_q + CtrW'(1);
        if (idx_q == CtrW'(NumHandles - 1)) begin
          state_d = htfl_pkg::SQ_IDLE;
          if (clr_rep_q) begin
            done_d   = 1'b1;
            status_d = htfl_pkg::ST_OK;
            hout_d   = '0;
            cnt_d    = '0;
            lout_d   = '0;
            dout_d   = '0;
            relout_d = '0;
          end
        end
      end
      htfl_pkg::SQ_IDLE: begin
        if (accept) begin
          case (htfl_pkg::func_e'(func_i))
            htfl_pkg::FN_RESET: begin
              state_d      = htfl_pkg::SQ_CLEAR;
              idx_d        = '0;
              clr_slot_d   = 1'b1;
              clr_mark_d   = 1'b0;
              clr_rep_d    = 1'b1;
              free_top_d   = '0;
              high_water_d = '0;
            end
            htfl_pkg::FN_GC_BEGIN: begin
              state_d    = htfl_pkg::SQ_CLEAR;
              idx_d      = '0;
              clr_slot_d = 1'b0;
              clr_mark_d = 1'b1;
              clr_rep_d  = 1'b1;
            end
            htfl_pkg::FN_GC_END: begin
              state_d = htfl_pkg::SQ_SWEEP_RD;
              idx_d   = CtrW'(1);
              rel_d   = '0;
            end
            default: begin
              state_d = htfl_pkg::SQ_EXEC;
            end
          endcase
        end
      end
      htfl_pkg::SQ_EXEC: begin
        state_d  = htfl_pkg::SQ_IDLE;
        done_d   = 1'b1;
        status_d = htfl_pkg::ST_OK;
        hout_d   = '0;
        cnt_d    = '0;
        lout_d   = '0;
        dout_d   = '0;
        relout_d = '0;
        case (func_q)
          htfl_pkg::FN_ALLOC: begin
            if (free_top_q != '0) begin
              free_top_d = free_top_m1;
              slot_we    = 1'b1;
              slot_waddr = free_rd_q;
              slot_wdata = {1'b1, {CntW{1'b0}}};
              hout_d     = free_rd_q;
            end else if (hw_one >= CtrW'(NumHandles)) begin
              high_water_d = hw_one;
              status_d     = htfl_pkg::ST_TABLE_FULL;
            end else begin
              high_water_d = hw_one + CtrW'(1);
              slot_we      = 1'b1;
              slot_waddr   = hw_one[HandleW-1:0];
              slot_wdata   = {1'b1, {CntW{1'b0}}};
              hout_d       = hw_one[HandleW-1:0];
            end
          end
          htfl_pkg::FN_RELEASE: begin
            if (h_in_range && slot_v) begin
              slot_we = 1'b1;
              if (free_top_q < CtrW'(NumHandles)) begin
                free_we    = 1'b1;
                free_top_d = free_top_q + CtrW'(1);
              end
            end else begin
              status_d = htfl_pkg::ST_BAD_HANDLE;
            end
          end
          htfl_pkg::FN_PUSH: begin
            if (!(h_in_range && slot_v)) begin
              status_d = htfl_pkg::ST_BAD_HANDLE;
            end else if (slot_len >= CntW'(RefsPerHandle)) begin
              status_d = htfl_pkg::ST_LIST_FULL;
              cnt_d    = slot_len;
            end else begin
              ref_we     = 1'b1;
              slot_we    = 1'b1;
              slot_wdata = {1'b1, slot_len + CntW'(1)};
              cnt_d      = slot_len + CntW'(1);
            end
          end
          htfl_pkg::FN_READ: begin
            if (!(h_in_range && slot_v)) begin
              status_d = htfl_pkg::ST_BAD_HANDLE;
            end else begin
              cnt_d = slot_len;
              if ((CntW'(ri_q) >= slot_len) || (32'(ri_q) >= RefsPerHandle)) begin
                status_d = htfl_pkg::ST_BAD_INDEX;
              end else begin
                lout_d = ref_rd_q[RefW-1:htfl_pkg::FieldW];
                dout_d = ref_rd_q[htfl_pkg::FieldW-1:0];
              end
            end
          end
          htfl_pkg::FN_GC_MARK: begin
            if (h_in_range) begin
              mark_we    = 1'b1;
              mark_wdata = 1'b1;
            end else begin
              status_d = htfl_pkg::ST_BAD_HANDLE;
            end
          end
          default: begin
            status_d = htfl_pkg::ST_OK;
          end
        endcase
      end
      htfl_pkg::SQ_SWEEP_RD: begin
        if (idx_q >= high_water_q) begin
          state_d  = htfl_pkg::SQ_IDLE;
          done_d   = 1'b1;
          status_d = htfl_pkg::ST_OK;
          hout_d   = '0;
          cnt_d    = '0;
          lout_d   = '0;
          dout_d   = '0;
          relout_d = rel_q;
        end else begin
          state_d = htfl_pkg::SQ_SWEEP_EX;
        end
      end
      htfl_pkg::SQ_SWEEP_EX: begin
        state_d    = htfl_pkg::SQ_SWEEP_RD;
        idx_d      = idx_q + CtrW'(1);
        slot_waddr = idx_q[HandleW-1:0];
        free_wdata = idx_q[HandleW-1:0];
        if (slot_v && !mark_rd_q) begin
          slot_we = 1'b1;
          if (free_top_q < CtrW'(NumHandles)) begin
            free_we    = 1'b1;
            free_top_d = free_top_q + CtrW'(1);
          end
          if (rel_q != '1) begin
            rel_d = rel_q + htfl_pkg::RelCountW'(1);
          end
        end
      end
      default: begin
        state_d = htfl_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htfl_pkg::SQ_CLEAR;
      idx_q        <= '0;
      clr_slot_q   <= 1'b1;
      clr_mark_q   <= 1'b1;
      clr_rep_q    <= 1'b0;
      free_top_q   <= '0;
      high_water_q <= '0;
      rel_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      clr_slot_q   <= clr_slot_d;
      clr_mark_q   <= clr_mark_d;
      clr_rep_q    <= clr_rep_d;
      free_top_q   <= free_top_d;
      high_water_q <= high_water_d;
      rel_q        <= rel_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= htfl_pkg::func_e'(func_i);
      h_q    <= handle_i;
      la_q   <= lines_ahead_i;
      di_q   <= drawable_index_i;
      ri_q   <= ref_index_i;
      base_q <= ref_base;
    end
    status_q <= status_d;
    hout_q   <= hout_d;
    cnt_q    <= cnt_d;
    lout_q   <= lout_d;
    dout_q   <= dout_d;
    relout_q <= relout_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_q <= mark_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    free_rd_q <= free_mem[free_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= {la_q, di_q};
    end
    ref_rd_q <= ref_mem[ref_raddr];
  end

  assign done_o               = done_q;
  assign status_o             = status_q;
  assign handle_out_o         = hout_q;
  assign ref_count_o          = cnt_q;
  assign lines_ahead_out_o    = lout_q;
  assign drawable_index_out_o = dout_q;
  assign released_count_o     = relout_q;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done pulse longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("no busy after accepted word");

  a_free_top_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_top_q == '0) || (free_top_q < high_water_q))
    else $error("free stack deeper than handles issued");

  a_high_water_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_water_q <= CtrW'(NumHandles))
    else $error("high-water mark beyond table");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == htfl_pkg::SQ_IDLE))
    else $error("result shown while sequencer busy");

endmodule
